// ----- src/isdo_pkg.sv -----
// ----------------------------------------------------------------------------
// isdo_pkg
// Shared types and codes for the integer stack/deque block: request and
// response words, decoded command word, and back-end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package isdo_pkg;

   // Request operation codes
   localparam logic [2:0] OP_PUSH_TOP    = 3'd0;
   localparam logic [2:0] OP_PUSH_BOTTOM = 3'd1;
   localparam logic [2:0] OP_SUB         = 3'd2;
   localparam logic [2:0] OP_SWAP        = 3'd3;

   // Response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Width of the reported entry count
   localparam int unsigned COUNT_W = 7;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] top_value;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_PUSH_TOP,
      KIND_PUSH_BOTTOM,
      KIND_SUB,
      KIND_SWAP,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_EXEC,
      BE_SWAP2
   } be_state_type;

endpackage

`default_nettype wire

// ----- src/integer_stack_deque_ops.sv -----
// ----------------------------------------------------------------------------
// integer_stack_deque_ops
// Bounded integer stack with bottom insertion, held in a ring of DEPTH words.
// ----------------------------------------------------------------------------
// The front end takes one request word per cycle into a two-entry command
// queue whenever the queue has room, so requests keep flowing while a result
// waits on rsp_ready. The back end runs one command at a time against a ring
// memory with one write port and one registered read port, with the top
// entry cached in a register: push top, push bottom, no operation and any
// rejected request complete from the idle state; subtract also goes through
// an execute state that uses the registered memory read of the second
// entry, and swap through execute and a second write state, as the single
// write port must write two entries. Each request yields exactly one response
// word. The memory needs no clearing after reset; only held entries are used.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_stack_deque_ops #(
   parameter int unsigned DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  isdo_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output isdo_pkg::rsp_type rsp_data
);
   import isdo_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;

   // Accept and decode
   isdo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // Execute and respond
   isdo_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/isdo_front.sv -----
// ----------------------------------------------------------------------------
// isdo_front
// Accepts request words, decodes the operation into a command kind and
// holds decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module isdo_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  isdo_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output isdo_pkg::cmd_type cmd_data
);
   import isdo_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    cmd_in;
   logic       push;
   logic       pop;

   // Decode the operation; unused codes act as no operation
   always_comb begin
      cmd_in.value = req_data.push_value;
      case (req_data.operation)
         OP_PUSH_TOP:    cmd_in.kind = KIND_PUSH_TOP;
         OP_PUSH_BOTTOM: cmd_in.kind = KIND_PUSH_BOTTOM;
         OP_SUB:         cmd_in.kind = KIND_SUB;
         OP_SWAP:        cmd_in.kind = KIND_SWAP;
         default:        cmd_in.kind = KIND_NOP;
      endcase
   end

   // Queue handshakes
   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the decoded word
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/isdo_back.sv -----
// ----------------------------------------------------------------------------
// isdo_back
// Executes decoded commands against the ring store. The top entry is cached
// in a register; the second entry is fetched through the memory's registered
// read port when a subtract or swap needs it. Results land in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module isdo_back #(
   parameter int unsigned DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  isdo_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output isdo_pkg::rsp_type rsp_data
);
   import isdo_pkg::*;

   localparam int unsigned IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [31:0]        entry_mem [DEPTH];

   be_state_type       state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [IW-1:0]      top_index_ff, top_index_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] top_val_ff, top_val_in;
   logic [31:0]        rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [IW-1:0]      idx_up;
   logic [IW-1:0]      idx_dn;
   logic [IW:0]        bottom_sum;
   logic [IW-1:0]      idx_bottom;
   logic               out_free;
   logic               start;
   logic               is_full;
   logic               is_short;
   logic               load;
   logic [1:0]         status_c;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic signed [31:0] diff;

   // Ring neighbors of the top and the free slot below the bottom
   always_comb begin
      idx_up     = (top_index_ff == IW'(DEPTH - 1)) ? '0 : top_index_ff + IW'(1);
      idx_dn     = (top_index_ff == '0) ? IW'(DEPTH - 1) : top_index_ff - IW'(1);
      bottom_sum = {1'b0, top_index_ff} + (IW+1)'(count_ff);
      if (bottom_sum >= (IW+1)'(DEPTH)) begin
         idx_bottom = IW'(bottom_sum - (IW+1)'(DEPTH));
      end else begin
         idx_bottom = bottom_sum[IW-1:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start     = (state_ff == BE_IDLE) && cmd_valid && out_free;
   assign cmd_ready = start;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_short  = (count_ff < CW'(2));
   assign diff      = $signed(rd_data_ff) - top_val_ff;

   // Sequence each command and form its result
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      top_index_in = top_index_ff;
      count_in     = count_ff;
      top_val_in   = top_val_ff;
      load         = 1'b0;
      status_c     = ST_OK;
      wr_en        = 1'b0;
      wr_addr      = top_index_ff;
      wr_data      = top_val_ff;
      case (state_ff)
         BE_IDLE: begin
            if (start) begin
               case (cmd_data.kind)
                  KIND_PUSH_TOP: begin
                     load = 1'b1;
                     if (is_full) begin
                        status_c = ST_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = idx_dn;
                        wr_data      = cmd_data.value;
                        top_index_in = idx_dn;
                        top_val_in   = cmd_data.value;
                        count_in     = count_ff + CW'(1);
                     end
                  end
                  KIND_PUSH_BOTTOM: begin
                     load = 1'b1;
                     if (is_full) begin
                        status_c = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = idx_bottom;
                        wr_data  = cmd_data.value;
                        count_in = count_ff + CW'(1);
                        if (count_ff == '0) begin
                           top_val_in = cmd_data.value;
                        end
                     end
                  end
                  KIND_SUB, KIND_SWAP: begin
                     if (is_short) begin
                        load     = 1'b1;
                        status_c = ST_SHORT;
                     end else begin
                        kind_in  = cmd_data.kind;
                        state_in = BE_EXEC;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         BE_EXEC: begin
            // Second entry is now in the read register
            wr_en   = 1'b1;
            wr_addr = idx_up;
            if (kind_ff == KIND_SUB) begin
               wr_data      = diff;
               top_index_in = idx_up;
               top_val_in   = diff;
               count_in     = count_ff - CW'(1);
               load         = 1'b1;
               state_in     = BE_IDLE;
            end else begin
               wr_data    = top_val_ff;
               top_val_in = $signed(rd_data_ff);
               state_in   = BE_SWAP2;
            end
         end
         BE_SWAP2: begin
            // Write the old second entry into the top slot
            wr_en    = 1'b1;
            wr_addr  = top_index_ff;
            wr_data  = top_val_ff;
            load     = 1'b1;
            state_in = BE_IDLE;
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase

      rsp_in.status      = status_c;
      rsp_in.top_value   = (count_in == '0) ? 32'sd0 : top_val_in;
      rsp_in.entry_count = COUNT_W'(count_in);
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         top_index_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_index_ff <= top_index_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      top_val_ff <= top_val_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Ring store: one write, one registered read of the second entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[idx_up];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- src/isdo_checker.sv -----
// ----------------------------------------------------------------------------
// isdo_checker
// Port-level checks on the response channel of the stack/deque block,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module isdo_checker #(
   parameter int unsigned DEPTH = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input isdo_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input isdo_pkg::rsp_type rsp_data
);
   import isdo_pkg::*;

   logic [COUNT_W-1:0] full_count;
   logic               req_seen;

   assign full_count = COUNT_W'(DEPTH);
   assign req_seen   = req_valid && req_ready && (req_data.operation != OP_PUSH_TOP);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // A full report shows a full store
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.entry_count == full_count)
      else $error("full status with store not full");

   // A too-short report shows fewer than two entries
   a_short_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_SHORT |-> rsp_data.entry_count < COUNT_W'(2))
      else $error("too-short status with two or more entries");

   // An empty store reports a zero top (checked only when DEPTH is below 128)
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_count == '0 && (DEPTH < 128 || !req_seen)
      && DEPTH < 128 |-> rsp_data.top_value == 32'sd0)
      else $error("nonzero top value on empty store");

   // No response straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind integer_stack_deque_ops isdo_checker #(.DEPTH(DEPTH)) u_checker (.*);

`default_nettype wire
